// File: design/json_object_key_value_splitter_macros.svh
// Assertion macros for the JSON object key/value splitter.
// Used by the top level; no other dependencies.
`ifndef JSON_OBJECT_KEY_VALUE_SPLITTER_MACROS_SVH
`define JSON_OBJECT_KEY_VALUE_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define JKVS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("JKVS same-cycle check failed");
`define JKVS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("JKVS next-cycle check failed");
`else
`define JKVS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define JKVS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: design/jkvs_pkg.sv
// Package for the JSON object key/value splitter: payload structs, phase codes,
// character constants and helper functions. No dependencies.
`timescale 1ns / 1ps

package jkvs_pkg;

    localparam int MAX_NESTING_DEFAULT = 255;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef enum logic [2:0] {
        PH_HEAD  = 3'd0,
        PH_KEY   = 3'd1,
        PH_COLON = 3'd2,
        PH_VALUE = 3'd3,
        PH_END   = 3'd4,
        PH_BAD   = 3'd5
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_is_key;
        logic       key_done;
        logic       item_done;
        logic       group_done;
        logic       group_dropped;
        logic       format_error;
        logic       rejected;
    } out_t;

    typedef struct packed {
        logic inside_string;
        logic escape_pending;
        logic group_open;
    } flags_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

// File: design/json_object_key_value_splitter.sv
// Top level of the JSON object key/value splitter: parser state registers,
// parser step and result register. Depends on jkvs_pkg, jkvs_parse, jkvs_out_reg.
//
// The s_ channel carries one item per transfer: a data byte (mode 0) or an end
// marker (mode 1) that resets the parser and reports an unfinished group.
// Every input transfer produces exactly one result transfer on the m_ channel,
// holding the byte with its key/value tag and the key, item and group marks.
// m_valid rises in the cycle after an input transfer. One item is taken per
// cycle while the receiver does not stall; the parser step is a single pass
// of compare logic between the state registers and the result register.
// While the receiver stalls, the finished result stays in the result register
// and s_ready drops until it is taken; s_ready is high whenever that register
// is empty or being read in the same cycle.
// Reset (aresetn low, synchronous) empties the result register and puts the
// parser in its head phase with zero depths and cleared flags.
`timescale 1ns / 1ps
`include "json_object_key_value_splitter_macros.svh"

module json_object_key_value_splitter #(
    parameter int MAX_NESTING = jkvs_pkg::MAX_NESTING_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  jkvs_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output jkvs_pkg::out_t m_data
);

    localparam int DepthW = $clog2(MAX_NESTING + 1);

    jkvs_pkg::phase_t  phase_reg;
    jkvs_pkg::phase_t  phase_next;
    logic [DepthW-1:0] obj_depth_reg;
    logic [DepthW-1:0] obj_depth_next;
    logic [DepthW-1:0] arr_depth_reg;
    logic [DepthW-1:0] arr_depth_next;
    jkvs_pkg::flags_t  flags_reg;
    jkvs_pkg::flags_t  flags_next;
    jkvs_pkg::out_t    res;
    logic              accept;

    assign accept = s_valid && s_ready;

    jkvs_parse #(
        .MAX_NESTING(MAX_NESTING)
    ) u_parse (
        .item_i      (s_data),
        .phase_i     (phase_reg),
        .obj_depth_i (obj_depth_reg),
        .arr_depth_i (arr_depth_reg),
        .flags_i     (flags_reg),
        .phase_o     (phase_next),
        .obj_depth_o (obj_depth_next),
        .arr_depth_o (arr_depth_next),
        .flags_o     (flags_next),
        .res_o       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= jkvs_pkg::PH_HEAD;
            obj_depth_reg <= '0;
            arr_depth_reg <= '0;
            flags_reg     <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            obj_depth_reg <= obj_depth_next;
            arr_depth_reg <= arr_depth_next;
            flags_reg     <= flags_next;
        end
    end

    jkvs_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .data_in (res),
        .ready   (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `JKVS_ASSERT_NEXT(a_end_resets, aclk, aresetn, accept && s_data.mode, (phase_reg == jkvs_pkg::PH_HEAD) && (obj_depth_reg == '0) && (flags_reg == '0))
    `JKVS_ASSERT_NEXT(a_group_done_ends, aclk, aresetn, accept && res.group_done, (phase_reg == jkvs_pkg::PH_END) && !flags_reg.group_open)
    `JKVS_ASSERT_IMP(a_valid_clean, aclk, aresetn, m_valid && m_data.out_valid, !m_data.format_error && !m_data.rejected && !m_data.group_dropped)
    `JKVS_ASSERT_IMP(a_empty_ready, aclk, aresetn, !m_valid, s_ready)

endmodule

// File: design/jkvs_parse.sv
// Combinational parser step: next phase, depths and flags, and the result item.
// Depends on jkvs_pkg.
`timescale 1ns / 1ps

module jkvs_parse #(
    parameter int MAX_NESTING = jkvs_pkg::MAX_NESTING_DEFAULT,
    localparam int DepthW = $clog2(MAX_NESTING + 1)
) (
    input  jkvs_pkg::in_t     item_i,
    input  jkvs_pkg::phase_t  phase_i,
    input  logic [DepthW-1:0] obj_depth_i,
    input  logic [DepthW-1:0] arr_depth_i,
    input  jkvs_pkg::flags_t  flags_i,
    output jkvs_pkg::phase_t  phase_o,
    output logic [DepthW-1:0] obj_depth_o,
    output logic [DepthW-1:0] arr_depth_o,
    output jkvs_pkg::flags_t  flags_o,
    output jkvs_pkg::out_t    res_o
);

    localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_NESTING);
    localparam logic [DepthW-1:0] DepthOne = DepthW'(1);

    logic [7:0] c;
    logic       space;
    logic       obj_full;
    logic       arr_full;
    logic       top_level;

    assign c         = item_i.data_byte;
    assign space     = jkvs_pkg::is_space(c);
    assign obj_full  = (obj_depth_i >= DepthMax);
    assign arr_full  = (arr_depth_i >= DepthMax);
    assign top_level = (obj_depth_i == DepthOne) && (arr_depth_i == '0);

    // Next state.
    always_comb begin
        phase_o     = phase_i;
        obj_depth_o = obj_depth_i;
        arr_depth_o = arr_depth_i;
        flags_o     = flags_i;
        if (item_i.mode) begin
            phase_o     = jkvs_pkg::PH_HEAD;
            obj_depth_o = '0;
            arr_depth_o = '0;
            flags_o     = '0;
        end else begin
            case (phase_i)
                jkvs_pkg::PH_HEAD: begin
                    if (c == jkvs_pkg::CH_LBRACE) begin
                        obj_depth_o        = DepthOne;
                        flags_o.group_open = 1'b1;
                        phase_o            = jkvs_pkg::PH_KEY;
                    end else begin
                        phase_o = jkvs_pkg::PH_BAD;
                    end
                end
                jkvs_pkg::PH_KEY: begin
                    if (flags_i.inside_string) begin
                        if (flags_i.escape_pending) begin
                            flags_o.escape_pending = 1'b0;
                        end else if (c == jkvs_pkg::CH_BACKSLASH) begin
                            flags_o.escape_pending = 1'b1;
                        end else if (c == jkvs_pkg::CH_QUOTE) begin
                            flags_o.inside_string = 1'b0;
                            phase_o               = jkvs_pkg::PH_COLON;
                        end
                    end else if (c == jkvs_pkg::CH_QUOTE) begin
                        flags_o.inside_string = 1'b1;
                    end else if (!space) begin
                        phase_o = jkvs_pkg::PH_BAD;
                    end
                end
                jkvs_pkg::PH_COLON: begin
                    if (c == jkvs_pkg::CH_COLON) begin
                        phase_o = jkvs_pkg::PH_VALUE;
                    end else if (!space) begin
                        phase_o = jkvs_pkg::PH_BAD;
                    end
                end
                jkvs_pkg::PH_VALUE: begin
                    if (flags_i.inside_string) begin
                        if (flags_i.escape_pending) begin
                            flags_o.escape_pending = 1'b0;
                        end else if (c == jkvs_pkg::CH_QUOTE) begin
                            flags_o.inside_string = 1'b0;
                        end else if (c == jkvs_pkg::CH_BACKSLASH) begin
                            flags_o.escape_pending = 1'b1;
                        end
                    end else if (!space) begin
                        case (c)
                            jkvs_pkg::CH_LBRACKET: begin
                                if (arr_full) begin
                                    phase_o = jkvs_pkg::PH_BAD;
                                end else begin
                                    arr_depth_o = arr_depth_i + DepthOne;
                                end
                            end
                            jkvs_pkg::CH_RBRACKET: begin
                                if (arr_depth_i == '0) begin
                                    phase_o = jkvs_pkg::PH_BAD;
                                end else begin
                                    arr_depth_o = arr_depth_i - DepthOne;
                                end
                            end
                            jkvs_pkg::CH_LBRACE: begin
                                if (obj_full) begin
                                    phase_o = jkvs_pkg::PH_BAD;
                                end else begin
                                    obj_depth_o = obj_depth_i + DepthOne;
                                end
                            end
                            jkvs_pkg::CH_RBRACE: begin
                                if (obj_depth_i <= DepthOne) begin
                                    obj_depth_o        = '0;
                                    flags_o.group_open = 1'b0;
                                    phase_o            = jkvs_pkg::PH_END;
                                end else begin
                                    obj_depth_o = obj_depth_i - DepthOne;
                                end
                            end
                            jkvs_pkg::CH_QUOTE: begin
                                flags_o.inside_string = 1'b1;
                            end
                            jkvs_pkg::CH_COMMA: begin
                                if (top_level) begin
                                    phase_o = jkvs_pkg::PH_KEY;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result item.
    always_comb begin
        res_o = '0;
        if (item_i.mode) begin
            res_o.group_dropped = flags_i.group_open && (phase_i != jkvs_pkg::PH_END);
        end else begin
            res_o.out_byte = c;
            case (phase_i)
                jkvs_pkg::PH_HEAD: begin
                    res_o.format_error = (c != jkvs_pkg::CH_LBRACE);
                end
                jkvs_pkg::PH_KEY: begin
                    if (flags_i.inside_string) begin
                        res_o.out_valid  = 1'b1;
                        res_o.out_is_key = 1'b1;
                        res_o.key_done   = !flags_i.escape_pending &&
                                           (c == jkvs_pkg::CH_QUOTE);
                    end else if (c == jkvs_pkg::CH_QUOTE) begin
                        res_o.out_valid  = 1'b1;
                        res_o.out_is_key = 1'b1;
                    end else begin
                        res_o.format_error = !space;
                    end
                end
                jkvs_pkg::PH_COLON: begin
                    res_o.format_error = (c != jkvs_pkg::CH_COLON) && !space;
                end
                jkvs_pkg::PH_VALUE: begin
                    if (flags_i.inside_string) begin
                        res_o.out_valid = 1'b1;
                    end else if (!space) begin
                        case (c)
                            jkvs_pkg::CH_LBRACKET: begin
                                res_o.format_error = arr_full;
                                res_o.out_valid    = !arr_full;
                            end
                            jkvs_pkg::CH_RBRACKET: begin
                                res_o.format_error = (arr_depth_i == '0);
                                res_o.out_valid    = (arr_depth_i != '0);
                            end
                            jkvs_pkg::CH_LBRACE: begin
                                res_o.format_error = obj_full;
                                res_o.out_valid    = !obj_full;
                            end
                            jkvs_pkg::CH_RBRACE: begin
                                if (obj_depth_i <= DepthOne) begin
                                    res_o.item_done  = 1'b1;
                                    res_o.group_done = 1'b1;
                                end else begin
                                    res_o.out_valid = 1'b1;
                                end
                            end
                            jkvs_pkg::CH_COMMA: begin
                                res_o.item_done = top_level;
                                res_o.out_valid = !top_level;
                            end
                            default: begin
                                res_o.out_valid = 1'b1;
                            end
                        endcase
                    end
                end
                default: begin
                    res_o.rejected = 1'b1;
                end
            endcase
        end
    end

endmodule

// File: design/jkvs_out_reg.sv
// Result register with valid/ready handshake toward the downstream receiver.
// Depends on jkvs_pkg.
`timescale 1ns / 1ps

module jkvs_out_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  jkvs_pkg::out_t data_in,
    output logic           ready,
    output logic           m_valid,
    input  logic           m_ready,
    output jkvs_pkg::out_t m_data
);

    logic           valid_reg;
    logic           valid_next;
    jkvs_pkg::out_t data_reg;

    assign ready      = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_in;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: verif/jkvs_split_checker.sv
// Checker for the JSON object key/value splitter: follows every input transfer with
// its own parser model and compares each result transfer with the expected one.
// Depends on jkvs_pkg for the payload structs, phase codes and character constants.
`timescale 1ns / 1ps

module jkvs_split_checker
    import jkvs_pkg::*;
#(
    parameter int MAX_NESTING = MAX_NESTING_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   errors,
    output int   pending
);

    phase_t ph;
    int     obj_level;
    int     arr_level;
    logic   in_quote;
    logic   esc_next;
    logic   group_live;
    out_t   expected_splits[$];
    int     mismatches = 0;

    function automatic logic blank_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    task automatic clear_parser();
        ph         = PH_HEAD;
        obj_level  = 0;
        arr_level  = 0;
        in_quote   = 1'b0;
        esc_next   = 1'b0;
        group_live = 1'b0;
    endtask

    task automatic go_bad(inout out_t r);
        ph             = PH_BAD;
        r.format_error = 1'b1;
        r.out_valid    = 1'b0;
    endtask

    task automatic parse_byte(input in_t it, output out_t r);
        logic [7:0] c;
        c = it.data_byte;
        r = '0;
        if (it.mode) begin
            r.group_dropped = group_live && ph != PH_END;
            clear_parser();
        end else begin
            r.out_byte = c;
            case (ph)
                PH_HEAD: begin
                    if (c == CH_LBRACE) begin
                        obj_level  = 1;
                        group_live = 1'b1;
                        ph         = PH_KEY;
                    end else begin
                        go_bad(r);
                    end
                end
                PH_KEY: begin
                    if (in_quote) begin
                        r.out_valid  = 1'b1;
                        r.out_is_key = 1'b1;
                        if (esc_next) begin
                            esc_next = 1'b0;
                        end else if (c == CH_BACKSLASH) begin
                            esc_next = 1'b1;
                        end else if (c == CH_QUOTE) begin
                            in_quote   = 1'b0;
                            r.key_done = 1'b1;
                            ph         = PH_COLON;
                        end
                    end else if (c == CH_QUOTE) begin
                        r.out_valid  = 1'b1;
                        r.out_is_key = 1'b1;
                        in_quote     = 1'b1;
                    end else if (!blank_char(c)) begin
                        go_bad(r);
                    end
                end
                PH_COLON: begin
                    if (c == CH_COLON) begin
                        ph = PH_VALUE;
                    end else if (!blank_char(c)) begin
                        go_bad(r);
                    end
                end
                PH_VALUE: begin
                    r.out_valid = 1'b1;
                    if (in_quote) begin
                        if (esc_next) begin
                            esc_next = 1'b0;
                        end else if (c == CH_QUOTE) begin
                            in_quote = 1'b0;
                        end else if (c == CH_BACKSLASH) begin
                            esc_next = 1'b1;
                        end
                    end else if (blank_char(c)) begin
                        r.out_valid = 1'b0;
                    end else if (c == CH_LBRACKET) begin
                        if (arr_level >= MAX_NESTING) go_bad(r);
                        else arr_level++;
                    end else if (c == CH_RBRACKET) begin
                        if (arr_level == 0) go_bad(r);
                        else arr_level--;
                    end else if (c == CH_LBRACE) begin
                        if (obj_level >= MAX_NESTING) go_bad(r);
                        else obj_level++;
                    end else if (c == CH_RBRACE) begin
                        if (obj_level <= 1) begin
                            obj_level    = 0;
                            r.item_done  = 1'b1;
                            r.group_done = 1'b1;
                            r.out_valid  = 1'b0;
                            group_live   = 1'b0;
                            ph           = PH_END;
                        end else begin
                            obj_level--;
                        end
                    end else if (c == CH_QUOTE) begin
                        in_quote = 1'b1;
                    end else if (c == CH_COMMA && obj_level == 1 && arr_level == 0) begin
                        r.item_done = 1'b1;
                        r.out_valid = 1'b0;
                        ph          = PH_KEY;
                    end
                end
                default: r.rejected = 1'b1;
            endcase
        end
    endtask

    task automatic compare_result(input out_t want, input out_t got);
        if (got !== want) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        out_t want;
        if (!aresetn) begin
            clear_parser();
            expected_splits.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_splits.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = expected_splits.pop_front();
                    compare_result(want, m_data);
                end
            end
            if (s_valid && s_ready) begin
                parse_byte(s_data, want);
                expected_splits.insert(expected_splits.size(), want);
            end
        end
        pending <= expected_splits.size();
        errors  <= mismatches;
    end

endmodule

// File: verif/json_object_key_value_splitter_tb.sv
// Testbench top for the JSON object key/value splitter: clock, reset, byte-stream
// stimulus and receiver flow control. Depends on jkvs_pkg, jkvs_split_checker and the block.
`timescale 1ns / 1ps

module json_object_key_value_splitter_tb;
    import jkvs_pkg::*;

    localparam int NEST             = MAX_NESTING_DEFAULT;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 125;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_t        s_data;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_t       m_data;
    int         fail_count;
    int         results_due;
    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         hold_left = 0;
    logic       hold_req = 1'b0;
    logic       hold_taken = 1'b0;
    int         cycle_count = 0;
    int         items_sent;
    logic [7:0] frame_q[$];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    json_object_key_value_splitter #(
        .MAX_NESTING(NEST)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    jkvs_split_checker #(
        .MAX_NESTING(NEST)
    ) i_split_checker (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .errors (fail_count),
        .pending(results_due)
    );

    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("json_object_key_value_splitter_tb: errors");
            $finish;
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] val);
        in_t it;
        it.mode      = mode;
        it.data_byte = val;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= it;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_end();
        send_item(1'b1, 8'($urandom));
    endtask

    task automatic add(input logic [7:0] c);
        frame_q.insert(frame_q.size(), c);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_item(1'b0, frame_q[i]);
        frame_q.delete();
    endtask

    task automatic add_ws();
        if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(3))
                    0: add(CH_SPACE);
                    1: add(CH_TAB);
                    2: add(CH_LF);
                    default: add(CH_CR);
                endcase
            end
        end
    endtask

    task automatic add_string();
        logic [7:0] c;
        add(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(9))
                0: begin
                    add(CH_BACKSLASH);
                    case ($urandom_range(2))
                        0: add(CH_QUOTE);
                        1: add(CH_BACKSLASH);
                        default: add(8'($urandom_range(32, 255)));
                    endcase
                end
                1: add(8'($urandom_range(128, 255)));
                default: begin
                    c = 8'($urandom_range(32, 126));
                    if (c == CH_QUOTE || c == CH_BACKSLASH) c = 8'h61;
                    add(c);
                end
            endcase
        end
        add(CH_QUOTE);
    endtask

    task automatic add_value(input int lvl);
        int    n;
        string lit;
        case ($urandom_range(lvl >= 3 ? 2 : 4))
            0: add_string();
            1: repeat ($urandom_range(1, 4)) add(8'($urandom_range(8'h2D, 8'h39)));
            2: begin
                case ($urandom_range(2))
                    0: lit = "true";
                    1: lit = "false";
                    default: lit = "null";
                endcase
                for (int i = 0; i < lit.len(); i++) add(lit[i]);
            end
            3: begin
                add(CH_LBRACKET);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i != 0) add(CH_COMMA);
                    add_ws();
                    add_value(lvl + 1);
                    add_ws();
                end
                add(CH_RBRACKET);
            end
            default: begin
                add(CH_LBRACE);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i != 0) add(CH_COMMA);
                    add_ws();
                    add_string();
                    add_ws();
                    add(CH_COLON);
                    add_ws();
                    add_value(lvl + 1);
                    add_ws();
                end
                add(CH_RBRACE);
            end
        endcase
    endtask

    task automatic build_object();
        int n;
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        add(CH_LBRACE);
        for (int i = 0; i < n; i++) begin
            if (i != 0) add(CH_COMMA);
            add_ws();
            add_string();
            add_ws();
            add(CH_COLON);
            add_ws();
            add_value(0);
            add_ws();
        end
        add_ws();
        add(CH_RBRACE);
    endtask

    task automatic random_frame();
        int pick;
        int cut;
        build_object();
        pick = $urandom_range(99);
        if (pick < 70) begin
            send_frame();
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom));
            end
        end else if (pick < 82) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
            send_frame();
        end else if (pick < 94) begin
            frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom);
            send_frame();
        end else begin
            frame_q.delete();
            repeat ($urandom_range(1, 8)) add(8'($urandom));
            send_frame();
        end
        send_end();
    endtask

    // Opens one level past the nesting limit inside the first value.
    task automatic deep_frame(input logic objects);
        add(CH_LBRACE);
        add(CH_QUOTE);
        add(8'h6B);
        add(CH_QUOTE);
        add(CH_COLON);
        repeat (objects ? NEST : NEST + 1) add(objects ? CH_LBRACE : CH_LBRACKET);
        add(CH_RBRACKET);
        send_frame();
        send_end();
    endtask

    initial begin
        int phase_start;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        items_sent         = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add(8'h00);
        send_frame();
        send_end();
        add(CH_LBRACE);
        add(8'hFF);
        send_frame();
        send_end();
        add(CH_LBRACE);
        add(CH_QUOTE);
        add(CH_BACKSLASH);
        add(CH_QUOTE);
        add(CH_QUOTE);
        add(8'h2D);
        send_frame();
        send_end();
        add(CH_LBRACE);
        add(CH_QUOTE);
        add(CH_QUOTE);
        add(CH_COLON);
        add(CH_RBRACKET);
        send_frame();
        send_end();
        add(CH_LBRACE);
        add(CH_QUOTE);
        add(CH_QUOTE);
        add(CH_COLON);
        add(8'h31);
        add(CH_RBRACE);
        add(8'h78);
        send_frame();
        send_end();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
                default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
            endcase
            if (p == 0) begin
                hold_req = 1'b1;
                deep_frame(1'b1);
            end
            if (p == 3) deep_frame(1'b0);
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_PER_PHASE) random_frame();
        end

        s_valid <= 1'b0;
        receiver_stall_pct = 0;
        while (results_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && results_due == 0) begin
            $display("json_object_key_value_splitter_tb: clean");
        end else begin
            $display("json_object_key_value_splitter_tb: errors");
        end
        $finish;
    end

endmodule
